>>> design/skt_pkg.sv
// Shared types, codes and sizes for the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int DEPTH_DEF = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LIST   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] value;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic [5:0]  entry_total;
    logic        last;
  } skt_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic list_emit;
  } skt_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       empty;
    logic       list_last;
  } skt_stat_t;

endpackage
`default_nettype wire

>>> design/skt_ctrl.sv
// Controller state machine sequencing table operations and record listing.
`default_nettype none
module skt_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t  cmd
);
  import skt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LIST = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.mode == MODE_LIST && !stat.empty) begin
          cmd.list_emit = 1'b1;
          state_nxt     = stat.list_last ? ST_IDLE : ST_LIST;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LIST: begin
        cmd.list_emit = 1'b1;
        state_nxt     = stat.list_last ? ST_IDLE : ST_LIST;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/skt_datapath.sv
// Record cells with parallel compare and shift, entry count and result register.
`default_nettype none
module skt_datapath #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  skt_pkg::skt_in_t   in_item,
  input  skt_pkg::skt_cmd_t  cmd,
  output skt_pkg::skt_stat_t stat,
  output logic               out_valid,
  output skt_pkg::skt_out_t  out_result
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [1:0]       mode_r;
  logic [31:0]      key_r;
  logic [31:0]      value_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [31:0]      keys_r [DEPTH];
  logic [31:0]      keys_nxt [DEPTH];
  logic [31:0]      vals_r [DEPTH];
  logic [31:0]      vals_nxt [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] bound;
  logic             full;
  logic             found;
  logic             do_insert;
  logic             do_delete;
  logic             list_last;
  logic             out_valid_r;
  logic             out_valid_nxt;
  skt_out_t         out_result_r;
  skt_out_t         out_result_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign found     = |(bound & eq);
  assign do_insert = cmd.exec && mode_r == MODE_INSERT && !full;
  assign do_delete = cmd.exec && mode_r == MODE_DELETE && found;
  assign list_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign stat.mode      = mode_r;
  assign stat.empty     = (count_r == '0);
  assign stat.list_last = list_last;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [31:0] prev_key;
    logic [31:0] prev_val;
    logic [31:0] next_key;
    logic [31:0] next_val;
    logic        prev_lt;

    assign lt[g] = (CNT_W'(g) < count_r) && (keys_r[g] < key_r);
    assign eq[g] = (CNT_W'(g) < count_r) && (keys_r[g] == key_r);

    if (g == 0) begin : g_first
      assign prev_key = key_r;
      assign prev_val = value_r;
      assign prev_lt  = 1'b1;
    end else begin : g_mid
      assign prev_key = keys_r[g-1];
      assign prev_val = vals_r[g-1];
      assign prev_lt  = lt[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_key = keys_r[g];
      assign next_val = vals_r[g];
    end else begin : g_body
      assign next_key = keys_r[g+1];
      assign next_val = vals_r[g+1];
    end

    assign bound[g] = !lt[g] && prev_lt;

    always_comb begin
      keys_nxt[g] = keys_r[g];
      vals_nxt[g] = vals_r[g];
      if (do_insert && !lt[g]) begin
        if (bound[g]) begin
          keys_nxt[g] = key_r;
          vals_nxt[g] = value_r;
        end else begin
          keys_nxt[g] = prev_key;
          vals_nxt[g] = prev_val;
        end
      end else if (do_delete && !lt[g]) begin
        keys_nxt[g] = next_key;
        vals_nxt[g] = next_val;
      end
    end
  end

  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.exec) begin
      out_result_nxt.out_key     = key_r;
      out_result_nxt.out_value   = '0;
      out_result_nxt.entry_total = 6'(count_nxt);
      out_result_nxt.last        = 1'b1;
      case (mode_r)
        MODE_INSERT: begin
          out_valid_nxt         = 1'b1;
          out_result_nxt.status = full ? STATUS_FULL : STATUS_OK;
        end
        MODE_DELETE: begin
          out_valid_nxt         = 1'b1;
          out_result_nxt.status = found ? STATUS_OK : STATUS_NOT_FOUND;
        end
        MODE_LIST: begin
          out_valid_nxt              = 1'b1;
          out_result_nxt.status      = STATUS_EMPTY;
          out_result_nxt.out_key     = '0;
          out_result_nxt.entry_total = '0;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end else if (cmd.list_emit) begin
      out_valid_nxt              = 1'b1;
      out_result_nxt.status      = STATUS_OK;
      out_result_nxt.out_key     = keys_r[idx_r];
      out_result_nxt.out_value   = vals_r[idx_r];
      out_result_nxt.entry_total = 6'(count_r);
      out_result_nxt.last        = list_last;
      idx_nxt                    = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_item.mode;
      key_r   <= in_item.key;
      value_r <= in_item.value;
    end
    keys_r       <= keys_nxt;
    vals_r       <= vals_nxt;
    idx_r        <= idx_nxt;
    out_result_r <= out_result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

>>> design/sorted_key_table_unit.sv
// Top level of the sorted key table: controller plus record datapath.
//
// Usage: drive in_item and raise start while busy is low; the transaction is
// taken at that clock edge. Modes: insert, delete by key, list all records.
// Results appear on out_result for one cycle each, marked by out_valid;
// the receiver cannot stall, so every strobed result must be captured.
// Insert and delete: busy stays high through the controller's execute step
// after the accepting edge, the single result strobes in the cycle after
// that, and a new start is accepted in that same cycle.
// List of N records: N results on consecutive cycles, the last one flagged;
// an empty table returns one result with the empty status. The unused mode
// returns nothing. The timing is set by the controller's execute step and by
// the single read port of the record cells, which gives one record per cycle.
// Reset (rst_n low, synchronous) empties the table and clears the strobe; no
// clearing pass follows, so the block is ready as soon as reset is released.
`default_nettype none
module sorted_key_table_unit #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  skt_pkg::skt_in_t  in_item,
  output logic              out_valid,
  output skt_pkg::skt_out_t out_result
);
  import skt_pkg::*;

  skt_cmd_t  cmd;
  skt_stat_t stat;

  skt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  skt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
`default_nettype wire
